// ===== rtl/cpt_pkg.sv =====
package cpt_pkg;

    // Field widths
    localparam int TIME_W       = 32;
    localparam int SPEED_W      = 16;
    localparam int AMOUNT_W     = 32;
    localparam int CMD_W        = 3;
    localparam int CLIP_ID_BITS = 16;
    localparam int NORM_W       = 16;
    localparam int NORM_OUT_W   = NORM_W + 1;

    // speed * amount is Q24.24; after the floor shift it is Q24.16 over 40 bits,
    // and adding the playhead needs one more bit
    localparam int PROD_W  = SPEED_W + AMOUNT_W;
    localparam int FRAC_SH = 8;
    localparam int SUM_W   = PROD_W - FRAC_SH + 1;
    localparam int CNT_W   = $clog2(SUM_W + 1);

    localparam logic [SPEED_W-1:0]    SPEED_RESET = SPEED_W'(256);
    localparam logic [NORM_OUT_W-1:0] NORM_ONE    = NORM_OUT_W'(1) << NORM_W;
    localparam logic [CNT_W-1:0]      SUM_STEPS   = CNT_W'(SUM_W);
    localparam logic [CNT_W-1:0]      NORM_STEPS  = CNT_W'(NORM_W);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK     = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_PLAY     = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_PAUSE    = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_RESUME   = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_STOP     = CMD_W'(4);
    localparam logic [CMD_W-1:0] CMD_SET_TIME = CMD_W'(5);

    // Request into the shared remainder unit
    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  steps;
        logic [TIME_W-1:0] rem_init;
        logic [SUM_W-1:0]  bits;
    } t_div_req;

    // Response from the shared remainder unit
    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] rem;
        logic [NORM_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/cpt_divider.sv =====
// Restoring remainder/quotient unit: one compare-subtract-shift per cycle while busy.
module cpt_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cpt_pkg::t_div_req          i_req,
    input  logic [cpt_pkg::TIME_W-1:0] i_divisor,
    output cpt_pkg::t_div_rsp          o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [cpt_pkg::CNT_W-1:0]   r_cnt;
    logic [cpt_pkg::TIME_W-1:0]  r_rem;
    logic [cpt_pkg::SUM_W-1:0]   r_bits;
    logic [cpt_pkg::NORM_W-1:0]  r_quot;

    logic [cpt_pkg::TIME_W:0]    trial;
    logic [cpt_pkg::TIME_W:0]    diff;
    logic                        ge;
    logic [cpt_pkg::TIME_W-1:0]  n_rem;

    // Shift in the next dividend bit and subtract where it fits
    always_comb begin
        trial = {r_rem, r_bits[cpt_pkg::SUM_W-1]};
        ge    = trial >= {1'b0, i_divisor};
        diff  = trial - {1'b0, i_divisor};
        n_rem = ge ? diff[cpt_pkg::TIME_W-1:0] : trial[cpt_pkg::TIME_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - cpt_pkg::CNT_W'(1);
                if (r_cnt == cpt_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem_init;
            r_bits <= i_req.bits;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_bits <= {r_bits[cpt_pkg::SUM_W-2:0], 1'b0};
            r_quot <= {r_quot[cpt_pkg::NORM_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
    assign o_rsp.quot = r_quot;

endmodule

// ===== rtl/clip_playhead_timer.sv =====
// Channel  | Valid        | Stall        | Payload
// ---------+--------------+--------------+---------------------------------------------
// command  | i_in_valid   | o_in_stall   | i_command, i_clip_id, i_clip_length,
//          |              |              | i_loop_request, i_restart_request, i_amount
// result   | o_out_valid  | i_out_stall  | o_play_time, o_normalized_time, o_active,
//          |              |              | o_finished, o_paused
// speed    | i_cfg_wr_en  | (none)       | i_cfg_wr_data
//
// One beat in gives one beat out; the input stalls from acceptance until the result is taken.
// From acceptance a command passes S_CMD, then S_SUM and, when looping, S_MOD for a running tick,
// then S_NORM and, when the normalised time divides, S_NWAIT, and last S_OUT.
// The shared remainder unit runs 41 steps for the loop wrap and 16 for the normalised time.
// Reset is synchronous, active low, and returns the playhead state to zero and the speed to 1.0.
// A stalled result holds until taken.
module clip_playhead_timer #(
    parameter int CLIP_ID_BITS = cpt_pkg::CLIP_ID_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_cfg_wr_en,
    input  logic signed [cpt_pkg::SPEED_W-1:0]    i_cfg_wr_data,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [cpt_pkg::CMD_W-1:0]             i_command,
    input  logic [CLIP_ID_BITS-1:0]               i_clip_id,
    input  logic [cpt_pkg::TIME_W-1:0]            i_clip_length,
    input  logic                                  i_loop_request,
    input  logic                                  i_restart_request,
    input  logic signed [cpt_pkg::AMOUNT_W-1:0]   i_amount,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [cpt_pkg::TIME_W-1:0]            o_play_time,
    output logic [cpt_pkg::NORM_OUT_W-1:0]        o_normalized_time,
    output logic                                  o_active,
    output logic                                  o_finished,
    output logic                                  o_paused
);

    localparam int TW = cpt_pkg::TIME_W;
    localparam int SW = cpt_pkg::SUM_W;
    localparam int PW = cpt_pkg::PROD_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMD   = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_NORM  = 3'd4;
    localparam logic [2:0] S_NWAIT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state, n_state;

    // Captured command beat
    logic [cpt_pkg::CMD_W-1:0]           r_cmd;
    logic [CLIP_ID_BITS-1:0]             r_id;
    logic [TW-1:0]                       r_len_in;
    logic                                r_loop_req;
    logic                                r_restart_req;
    logic signed [cpt_pkg::AMOUNT_W-1:0] r_amount;

    // Playhead state
    logic                                r_loaded, n_loaded;
    logic [CLIP_ID_BITS-1:0]             r_clip, n_clip;
    logic [TW-1:0]                       r_length, n_length;
    logic [TW-1:0]                       r_playhead, n_playhead;
    logic                                r_loop, n_loop;
    logic                                r_done, n_done;
    logic                                r_hold, n_hold;
    logic signed [cpt_pkg::SPEED_W-1:0]  r_speed;

    // Working registers
    logic signed [PW-1:0]                r_prod, n_prod;
    logic                                r_neg, n_neg;
    logic [cpt_pkg::NORM_OUT_W-1:0]      r_norm, n_norm;

    logic [SW-1:0]                       sum;
    logic [SW-1:0]                       sum_abs;
    logic [TW-1:0]                       set_pos;
    logic [TW-1:0]                       mod_rem;

    cpt_pkg::t_div_req                   div_req;
    cpt_pkg::t_div_rsp                   div_rsp;

    cpt_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .i_divisor (r_length),
        .o_rsp     (div_rsp)
    );

    // Playhead plus floor(speed * delta / 256): the arithmetic shift floors toward
    // minus infinity, then widen by one bit for the add.
    assign sum     = {1'b0, {(SW-TW-1){1'b0}}, r_playhead}
                   + {r_prod[PW-1], r_prod[PW-1:cpt_pkg::FRAC_SH]};
    assign sum_abs = sum[SW-1] ? (~sum + SW'(1)) : sum;

    // set_time target clamped into [0, length]
    assign set_pos = r_amount[cpt_pkg::AMOUNT_W-1]      ? '0       :
                     (TW'(r_amount) > r_length)           ? r_length :
                     TW'(r_amount);

    // Non-negative modulo: fold a negative remainder back from the length
    assign mod_rem = (r_neg && (div_rsp.rem != '0)) ? (r_length - div_rsp.rem)
                                                    : div_rsp.rem;

    always_comb begin
        n_state    = r_state;
        n_loaded   = r_loaded;
        n_clip     = r_clip;
        n_length   = r_length;
        n_playhead = r_playhead;
        n_loop     = r_loop;
        n_done     = r_done;
        n_hold     = r_hold;
        n_prod     = r_prod;
        n_neg      = r_neg;
        n_norm     = r_norm;
        div_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMD;
                end
            end

            S_CMD: begin
                n_state = S_NORM;
                unique case (r_cmd)
                    cpt_pkg::CMD_TICK: begin
                        // Drop the tick when idle, paused or finished
                        if (r_loaded && !r_done && !r_hold) begin
                            if (r_length == '0) begin
                                n_playhead = '0;
                                n_done     = 1'b1;
                            end else begin
                                n_prod  = r_speed * r_amount;
                                n_state = S_SUM;
                            end
                        end
                    end
                    cpt_pkg::CMD_PLAY: begin
                        if (!(r_loaded && (r_clip == r_id)) || r_restart_req) begin
                            n_playhead = '0;
                        end
                        n_loaded = 1'b1;
                        n_clip   = r_id;
                        n_length = r_len_in;
                        n_loop   = r_loop_req;
                        n_done   = 1'b0;
                        n_hold   = 1'b0;
                    end
                    cpt_pkg::CMD_PAUSE: begin
                        if (r_loaded && !r_done) begin
                            n_hold = 1'b1;
                        end
                    end
                    cpt_pkg::CMD_RESUME: begin
                        if (r_loaded && !r_done) begin
                            n_hold = 1'b0;
                        end
                    end
                    cpt_pkg::CMD_STOP: begin
                        // Keep loop mode; clear everything else
                        n_loaded   = 1'b0;
                        n_clip     = '0;
                        n_length   = '0;
                        n_playhead = '0;
                        n_done     = 1'b0;
                        n_hold     = 1'b0;
                    end
                    cpt_pkg::CMD_SET_TIME: begin
                        if (!r_loaded) begin
                            n_playhead = '0;
                        end else begin
                            n_playhead = set_pos;
                            n_done     = !r_loop && (set_pos >= r_length);
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_SUM: begin
                if (r_loop) begin
                    // Wrap: remainder of |sum| by the length, sign fixed afterwards
                    n_neg            = sum[SW-1];
                    div_req.start    = 1'b1;
                    div_req.steps    = cpt_pkg::SUM_STEPS;
                    div_req.rem_init = '0;
                    div_req.bits     = sum_abs;
                    n_state          = S_MOD;
                end else begin
                    if (sum[SW-1]) begin
                        n_playhead = '0;
                        n_done     = 1'b1;
                    end else if (sum >= {{(SW-TW){1'b0}}, r_length}) begin
                        n_playhead = r_length;
                        n_done     = 1'b1;
                    end else begin
                        n_playhead = sum[TW-1:0];
                    end
                    n_state = S_NORM;
                end
            end

            S_MOD: begin
                if (div_rsp.done) begin
                    n_playhead = mod_rem;
                    n_state    = S_NORM;
                end
            end

            S_NORM: begin
                if (!r_loaded || (r_length == '0)) begin
                    n_norm  = '0;
                    n_state = S_OUT;
                end else if (r_playhead >= r_length) begin
                    n_norm  = cpt_pkg::NORM_ONE;
                    n_state = S_OUT;
                end else begin
                    // Fraction playhead / length, one quotient bit a step
                    div_req.start    = 1'b1;
                    div_req.steps    = cpt_pkg::NORM_STEPS;
                    div_req.rem_init = r_playhead;
                    div_req.bits     = '0;
                    n_state          = S_NWAIT;
                end
            end

            S_NWAIT: begin
                if (div_rsp.done) begin
                    n_norm  = {1'b0, div_rsp.quot};
                    n_state = S_OUT;
                end
            end

            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_loaded   <= 1'b0;
            r_clip     <= '0;
            r_length   <= '0;
            r_playhead <= '0;
            r_loop     <= 1'b0;
            r_done     <= 1'b0;
            r_hold     <= 1'b0;
            r_speed    <= cpt_pkg::SPEED_RESET;
        end else begin
            r_state    <= n_state;
            r_loaded   <= n_loaded;
            r_clip     <= n_clip;
            r_length   <= n_length;
            r_playhead <= n_playhead;
            r_loop     <= n_loop;
            r_done     <= n_done;
            r_hold     <= n_hold;
            if (i_cfg_wr_en) begin
                r_speed <= i_cfg_wr_data;
            end
        end
    end

    // Capture the beat on acceptance; working registers need no reset
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_cmd         <= i_command;
            r_id          <= i_clip_id;
            r_len_in      <= i_clip_length;
            r_loop_req    <= i_loop_request;
            r_restart_req <= i_restart_request;
            r_amount      <= i_amount;
        end
        r_prod <= n_prod;
        r_neg  <= n_neg;
        r_norm <= n_norm;
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = (r_state == S_OUT);
    assign o_play_time       = r_playhead;
    assign o_normalized_time = r_norm;
    assign o_active          = r_loaded;
    assign o_finished        = r_done;
    assign o_paused          = r_hold;

endmodule

// ===== tb/tb.sv =====
module tb;
    import cpt_pkg::*;

    // Command codes the block must treat as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_A = CMD_W'(6);
    localparam logic [CMD_W-1:0] CMD_SPARE_B = CMD_W'(7);

    localparam int RESET_CYCLES    = 8;
    localparam int PHASES          = 8;
    localparam int BEATS_PER_PHASE = 94;
    // A looping tick is the slowest command
    localparam int TAIL_CYCLES     = 80;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int QUIET_PHASE     = 2;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [CLIP_ID_BITS-1:0] clip;
        logic [TIME_W-1:0]       len;
        logic                    loop_req;
        logic                    restart_req;
        logic [AMOUNT_W-1:0]     amount;
    } t_cmd_beat;

    localparam int BEAT_W = $bits(t_cmd_beat);

    typedef struct packed {
        logic [TIME_W-1:0]     play_time;
        logic [NORM_OUT_W-1:0] norm;
        logic                  active;
        logic                  finished;
        logic                  paused;
    } t_status;

    // One row of the directed table: a command beat and, where it is plain to
    // see, the status it must give
    typedef struct {
        t_cmd_beat beat;
        bit        fixed;
        t_status   want;
    } t_dir_row;

    // Block ports
    logic                         i_clk             = 1'b0;
    logic                         i_rst_n           = 1'b0;
    logic                         i_cfg_wr_en       = 1'b0;
    logic signed [SPEED_W-1:0]    i_cfg_wr_data     = '0;
    logic                         i_in_valid        = 1'b0;
    logic                         o_in_stall;
    logic [CMD_W-1:0]             i_command         = '0;
    logic [CLIP_ID_BITS-1:0]      i_clip_id         = '0;
    logic [TIME_W-1:0]            i_clip_length     = '0;
    logic                         i_loop_request    = 1'b0;
    logic                         i_restart_request = 1'b0;
    logic signed [AMOUNT_W-1:0]   i_amount          = '0;
    logic                         o_out_valid;
    logic                         i_out_stall       = 1'b0;
    logic [TIME_W-1:0]            o_play_time;
    logic [NORM_OUT_W-1:0]        o_normalized_time;
    logic                         o_active;
    logic                         o_finished;
    logic                         o_paused;

    // Shadow of the playhead state, advanced on every accepted command beat
    logic                         m_loaded;
    logic [CLIP_ID_BITS-1:0]      m_clip;
    logic [TIME_W-1:0]            m_len;
    logic [TIME_W-1:0]            m_head;
    logic                         m_loop;
    logic                         m_done;
    logic                         m_hold;
    logic signed [SPEED_W-1:0]    m_speed;

    t_status                      status_due[$];
    t_dir_row                     dir_rows[$];
    t_status                      got_status;
    t_status                      want_status;
    t_status                      next_status;
    bit                           fixed_on   = 1'b0;
    t_status                      fixed_want = '0;
    bit                           no_idle    = 1'b0;
    int                           mismatch_count = 0;
    int                           results_seen   = 0;
    int                           cycle_count    = 0;

    clip_playhead_timer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_clip_id         (i_clip_id),
        .i_clip_length     (i_clip_length),
        .i_loop_request    (i_loop_request),
        .i_restart_request (i_restart_request),
        .i_amount          (i_amount),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_play_time       (o_play_time),
        .o_normalized_time (o_normalized_time),
        .o_active          (o_active),
        .o_finished        (o_finished),
        .o_paused          (o_paused)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Print one line per wrong field and count it
    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        $display("mismatch on %s at result %0d: got %0h, want %0h",
                 what, results_seen, got, want);
        mismatch_count++;
    endtask

    // Apply one command beat to the shadow state and give the status it yields.
    // The tick step is speed * amount in Q24.24, floored down to Q24.16; the
    // loop wrap is a non-negative modulo, one-shot play clamps at either end.
    task automatic advance_playhead(input t_cmd_beat b, output t_status s);
        longint            prod;
        longint            sum;
        longint            len_l;
        longint            r;
        logic [47:0]       rem;
        logic [NORM_W-1:0] q;
        bit                same;
        int                k;

        case (b.cmd)
            CMD_TICK: begin
                if (m_loaded && !m_done && !m_hold) begin
                    if (m_len == '0) begin
                        // zero-length clip finishes at once, looping or not
                        m_head = '0;
                        m_done = 1'b1;
                    end else begin
                        len_l = longint'(m_len);
                        prod  = longint'(m_speed) * longint'(signed'(b.amount));
                        sum   = longint'(m_head) + (prod >>> FRAC_SH);
                        if (m_loop) begin
                            r = sum % len_l;
                            if (r < 0) r = r + len_l;
                            m_head = r[TIME_W-1:0];
                        end else if (sum >= len_l) begin
                            m_head = m_len;
                            m_done = 1'b1;
                        end else if (sum < 0) begin
                            m_head = '0;
                            m_done = 1'b1;
                        end else begin
                            m_head = sum[TIME_W-1:0];
                        end
                    end
                end
            end
            CMD_PLAY: begin
                // same clip keeps its playhead unless a restart is asked
                same     = m_loaded && (m_clip == b.clip);
                m_loaded = 1'b1;
                m_clip   = b.clip;
                m_len    = b.len;
                m_loop   = b.loop_req;
                m_done   = 1'b0;
                m_hold   = 1'b0;
                if (!same || b.restart_req) m_head = '0;
            end
            CMD_PAUSE: begin
                if (m_loaded && !m_done) m_hold = 1'b1;
            end
            CMD_RESUME: begin
                if (m_loaded && m_hold && !m_done) m_hold = 1'b0;
            end
            CMD_STOP: begin
                // loop mode survives a stop
                m_loaded = 1'b0;
                m_clip   = '0;
                m_len    = '0;
                m_head   = '0;
                m_done   = 1'b0;
                m_hold   = 1'b0;
            end
            CMD_SET_TIME: begin
                if (!m_loaded) begin
                    m_head = '0;
                end else begin
                    if (b.amount[AMOUNT_W-1])  m_head = '0;
                    else if (b.amount > m_len) m_head = m_len;
                    else                       m_head = b.amount;
                    m_done = !m_loop && (m_head >= m_len);
                end
            end
            default: begin
            end
        endcase

        s.play_time = m_head;
        s.active    = m_loaded;
        s.finished  = m_done;
        s.paused    = m_hold;
        // Normalised time: restoring divide of head by length, 16 quotient bits
        if (!m_loaded || m_len == '0) begin
            s.norm = '0;
        end else if (m_head >= m_len) begin
            s.norm = NORM_ONE;
        end else begin
            rem = {16'b0, m_head};
            q   = '0;
            for (k = 0; k < NORM_W; k++) begin
                rem = rem << 1;
                q   = {q[NORM_W-2:0], 1'b0};
                if (rem >= {16'b0, m_len}) begin
                    rem  = rem - {16'b0, m_len};
                    q[0] = 1'b1;
                end
            end
            s.norm = {1'b0, q};
        end
    endtask

    // Check the result beat against the oldest status due, then record any
    // command beat taken on the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_loaded = 1'b0;
            m_clip   = '0;
            m_len    = '0;
            m_head   = '0;
            m_loop   = 1'b0;
            m_done   = 1'b0;
            m_hold   = 1'b0;
            m_speed  = SPEED_RESET;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got_status = {o_play_time, o_normalized_time, o_active, o_finished,
                              o_paused};
                if (status_due.size() == 0) begin
                    flag_mismatch("unexpected result beat", 64'(got_status), 64'd0);
                end else begin
                    want_status = status_due.pop_front();
                    if (got_status.play_time !== want_status.play_time)
                        flag_mismatch("play_time", 64'(got_status.play_time),
                                      64'(want_status.play_time));
                    if (got_status.norm !== want_status.norm)
                        flag_mismatch("normalized_time", 64'(got_status.norm),
                                      64'(want_status.norm));
                    if (got_status.active !== want_status.active)
                        flag_mismatch("active", 64'(got_status.active),
                                      64'(want_status.active));
                    if (got_status.finished !== want_status.finished)
                        flag_mismatch("finished", 64'(got_status.finished),
                                      64'(want_status.finished));
                    if (got_status.paused !== want_status.paused)
                        flag_mismatch("paused", 64'(got_status.paused),
                                      64'(want_status.paused));
                end
                results_seen++;
            end
            if (i_cfg_wr_en) m_speed = i_cfg_wr_data;
            if (i_in_valid && !o_in_stall) begin
                advance_playhead({i_command, i_clip_id, i_clip_length, i_loop_request,
                                  i_restart_request, i_amount}, next_status);
                // a pinned table row overrides the shadow, which still advances
                status_due.push_back(fixed_on ? fixed_want : next_status);
            end
        end
    end

    // Receiver: hold off the result beat in about a quarter of cycles
    always @(negedge i_clk) begin
        i_out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 25);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic add_row(input logic [CMD_W-1:0] cmd,
                           input logic [CLIP_ID_BITS-1:0] clip,
                           input logic [TIME_W-1:0] len, input logic lp, input logic rs,
                           input logic [AMOUNT_W-1:0] amt, input bit fixed = 1'b0,
                           input logic [TIME_W-1:0] t = '0,
                           input logic [NORM_OUT_W-1:0] n = '0,
                           input logic a = 1'b0, input logic f = 1'b0,
                           input logic p = 1'b0);
        t_dir_row row;
        row.beat  = {cmd, clip, len, lp, rs, amt};
        row.fixed = fixed;
        row.want  = {t, n, a, f, p};
        dir_rows.push_back(row);
    endtask

    // Build a command beat; most are well-formed play/tick/set_time traffic on a
    // loaded clip, the rest pauses, resumes, stops and spare codes
    function automatic t_cmd_beat random_beat();
        t_cmd_beat b;
        int        pick;

        b    = BEAT_W'({$urandom, $urandom, $urandom});
        pick = $urandom_range(99);
        if (!m_loaded && pick < 80) b.cmd = CMD_PLAY;
        else if (pick < 45)         b.cmd = CMD_TICK;
        else if (pick < 57)         b.cmd = CMD_PLAY;
        else if (pick < 65)         b.cmd = CMD_PAUSE;
        else if (pick < 73)         b.cmd = CMD_RESUME;
        else if (pick < 77)         b.cmd = CMD_STOP;
        else if (pick < 95)         b.cmd = CMD_SET_TIME;
        else if (pick < 98)         b.cmd = CMD_SPARE_A;
        else                        b.cmd = CMD_SPARE_B;

        case (b.cmd)
            CMD_PLAY: begin
                case ($urandom_range(4))
                    0:       b.clip = '0;
                    1:       b.clip = '1;
                    2:       b.clip = CLIP_ID_BITS'($urandom);
                    default: b.clip = m_clip;
                endcase
                case ($urandom_range(9))
                    0:       b.len = '0;
                    1:       b.len = '1;
                    2:       b.len = $urandom;
                    default: b.len = $urandom_range(32'h0008_0000, 1);
                endcase
            end
            CMD_TICK: begin
                case ($urandom_range(6))
                    0:       b.amount = $urandom;
                    1:       b.amount = '0;
                    default: b.amount = $urandom_range(32'h0004_0000) - 32'h0002_0000;
                endcase
            end
            CMD_SET_TIME: begin
                case ($urandom_range(3))
                    0:       b.amount = $urandom;
                    1:       b.amount = m_len + $urandom_range(16);
                    default: b.amount = $urandom_range(m_len);
                endcase
            end
            default: begin
            end
        endcase
        return b;
    endfunction

    // Offer one command beat, entered and left at a falling edge. Valid stays
    // high into the next beat unless an idle cycle is drawn.
    task automatic send(input t_cmd_beat b, input bit fixed, input t_status want);
        while (!no_idle && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        fixed_on          = fixed;
        fixed_want        = want;
        i_command         <= b.cmd;
        i_clip_id         <= b.clip;
        i_clip_length     <= b.len;
        i_loop_request    <= b.loop_req;
        i_restart_request <= b.restart_req;
        i_amount          <= b.amount;
        i_in_valid        <= 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every status due has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (status_due.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        // Directed rows at the reset speed of 1.0. Pinned rows: idle block,
        // one-shot end, clamped set_time, zero length, stop and spare codes.
        add_row(CMD_TICK,     '0, '0, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'b1);
        add_row(CMD_PAUSE,    '0, '0, 1'b0, 1'b0, '0, 1'b1);
        add_row(CMD_RESUME,   '0, '0, 1'b0, 1'b0, '0, 1'b1);
        add_row(CMD_SET_TIME, '0, '0, 1'b0, 1'b0, 32'h0000_0005, 1'b1);
        add_row(CMD_PLAY,     '1, '1, 1'b0, 1'b0, '0, 1'b1, '0, '0, 1'b1);
        add_row(CMD_TICK,     '0, '0, 1'b0, 1'b0, 32'h7FFF_FFFF);
        add_row(CMD_TICK,     '0, '0, 1'b0, 1'b0, 32'h7FFF_FFFF);
        // run off the end of a one-shot clip
        add_row(CMD_TICK,     '0, '0, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'b1, '1, NORM_ONE,
                1'b1, 1'b1);
        add_row(CMD_PAUSE,    '0, '0, 1'b0, 1'b0, '0);
        // same clip, shorter length: playhead stays beyond the end
        add_row(CMD_PLAY,     '1, 32'h0001_0000, 1'b1, 1'b0, '0);
        add_row(CMD_TICK,     '0, '0, 1'b0, 1'b0, '0);
        add_row(CMD_TICK,     '0, '0, 1'b0, 1'b0, 32'h8000_0000);
        add_row(CMD_PAUSE,    '0, '0, 1'b0, 1'b0, '0);
        add_row(CMD_TICK,     '0, '0, 1'b0, 1'b0, 32'h0000_1000);
        add_row(CMD_RESUME,   '0, '0, 1'b0, 1'b0, '0);
        add_row(CMD_SET_TIME, '0, '0, 1'b0, 1'b0, 32'h8000_0000);
        add_row(CMD_SET_TIME, '0, '0, 1'b0, 1'b0, 32'h7FFF_FFFF);
        add_row(CMD_PLAY,     '1, 32'h0001_0000, 1'b0, 1'b1, '0, 1'b1, '0, '0, 1'b1);
        add_row(CMD_SET_TIME, '0, '0, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'b1, 32'h0001_0000,
                NORM_ONE, 1'b1, 1'b1);
        add_row(CMD_PLAY,     '0, '0, 1'b1, 1'b0, '0, 1'b1, '0, '0, 1'b1);
        add_row(CMD_TICK,     '0, '0, 1'b0, 1'b0, 32'h0000_0100, 1'b1, '0, '0, 1'b1, 1'b1);
        add_row(CMD_STOP,     '0, '0, 1'b0, 1'b0, '0, 1'b1);
        add_row(CMD_SPARE_A,  '1, '1, 1'b1, 1'b1, '1, 1'b1);
        add_row(CMD_SPARE_B,  '1, '1, 1'b1, 1'b1, '1, 1'b1);
        add_row(CMD_PLAY,     16'h1234, 32'h0003_0000, 1'b0, 1'b0, '0);
        // step back past zero on a one-shot clip
        add_row(CMD_TICK,     '0, '0, 1'b0, 1'b0, 32'hFFFF_0000);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) send(dir_rows[k].beat, dir_rows[k].fixed, dir_rows[k].want);

        // Random phases, each at its own speed; the speed is only rewritten
        // once the block has gone quiet
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            i_cfg_wr_en <= 1'b1;
            case (ph)
                0:       i_cfg_wr_data <= 16'sh7FFF;
                1:       i_cfg_wr_data <= 16'sh8000;
                2:       i_cfg_wr_data <= 16'sh0000;
                3:       i_cfg_wr_data <= -16'sd256;
                4:       i_cfg_wr_data <= 16'sh0001;
                5:       i_cfg_wr_data <= 16'sh0200;
                default: i_cfg_wr_data <= SPEED_W'($urandom);
            endcase
            @(negedge i_clk);
            i_cfg_wr_en <= 1'b0;
            // one phase runs flat out on both sides
            no_idle = (ph == QUIET_PHASE);
            repeat (BEATS_PER_PHASE) send(random_beat(), 1'b0, '0);
        end

        drain();
        no_idle = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (status_due.size() != 0)
            flag_mismatch("results never delivered", 64'(status_due.size()), 64'd0);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
